/* rtl/i2cee_pkg.sv */
`default_nettype none

package i2cee_pkg;

	// Storage depth default and fixed field widths
	localparam int MEM_DEPTH_DEF = 4096;
	localparam int PTR_W         = 16;
	localparam int CFG_W         = 13;
	localparam int SIZE_W        = 13;

	// Register reset values
	localparam logic [7:0]        DEV_ADDR_RST  = 8'd160;
	localparam logic [7:0]        ADDR_MASK_RST = 8'd1;
	localparam logic [SIZE_W-1:0] MEM_SIZE_RST  = 13'd4096;

	// Reply code, erased byte value and largest one-byte memory size
	localparam logic [7:0] ACK_DATA   = 8'd1;
	localparam logic [7:0] ERASED     = 8'hFF;
	localparam logic [7:0] ONE_BYTE_MAX = 8'd255;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DEV_ADDR  = 2'd0,
		REG_ADDR_MASK = 2'd1,
		REG_MEM_SIZE  = 2'd2
	} cfg_reg_t;

	// One bus event
	typedef struct packed {
		logic       is_stop;
		logic       is_start;
		logic       is_write;
		logic       is_read;
		logic [7:0] bus_address;
		logic [7:0] bus_data;
	} evt_t;

	// One reply
	typedef struct packed {
		logic       reply_is_data;
		logic [7:0] reply_address;
		logic [7:0] reply_data;
		logic       last;
	} rsp_t;

endpackage

`default_nettype wire

/* rtl/i2cee_store.sv */
`default_nettype none

module i2cee_store import i2cee_pkg::*; #(
	parameter int DEPTH = MEM_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [7:0]               wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [7:0]               rd_data,
	output logic                          busy
);

	localparam int AW = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic          busy_q;
	logic [7:0]    rd_data_q;

	// Sweep every entry to the erased value after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Write port, shared between the sweep and item stores
	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= ERASED;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; hold the last byte until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

/* rtl/i2c_eeprom_target.sv */
// An item's first reply passes the reply-set register pend_s1, then the reply register,
// before it is on rsp. Replies leave one per cycle while rsp_stall is low; an item has
// at most three, drained by the single reply register, and a new item enters once the
// reply set is empty or hands over its final reply. Storage is one byte-wide memory
// with a registered read port. Reset: control clears at once; then a sweep writes 0xFF
// to all MEM_DEPTH entries while evt_stall is high (configuration writes still land).
`default_nettype none

module i2c_eeprom_target import i2cee_pkg::*; #(
	parameter int MEM_DEPTH = MEM_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             evt_valid,
	output logic                  evt_stall,
	input  wire evt_t             evt,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output rsp_t                  rsp,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	localparam int AW   = $clog2(MEM_DEPTH);
	localparam int SZ_W = $clog2(MEM_DEPTH + 1);
	localparam int CW   = (SZ_W > SIZE_W) ? SZ_W : SIZE_W;
	localparam logic [1:0] IDX_MAX = 2'd2;

	typedef struct packed {
		logic rd;
		logic wr;
		logic st;
	} pend_t;

	// Configuration and control state
	logic [7:0]        dev_q;
	logic [7:0]        mask_q;
	logic [SIZE_W-1:0] size_q;
	logic [7:0]        sel_q;
	logic [1:0]        idx_q;
	logic [PTR_W-1:0]  ptr_q;

	// Reply set of the item in flight
	pend_t       pend_s1;
	logic [7:0]  addr_s1;
	logic        fwd_s1;
	logic [7:0]  fwdd_s1;

	logic        rsp_valid_q;
	rsp_t        rsp_q;

	// Accept-side decode
	logic [CW-1:0]    size_raw;
	logic [CW-1:0]    size_eff;
	logic [PTR_W-1:0] lim;
	logic             two_bytes;
	logic [7:0]       sel0;
	logic [7:0]       sel1;
	logic [1:0]       idx0;
	logic [1:0]       idx1;
	logic [1:0]       idx2;
	logic [PTR_W-1:0] ptr0;
	logic [PTR_W-1:0] ptr1;
	logic [PTR_W-1:0] ptr2;
	logic [PTR_W-1:0] ptr_or;
	logic [PTR_W-1:0] acc0;
	logic [PTR_W-1:0] acc1;
	logic             match;
	logic             ack_start;
	logic             do_wr;
	logic             do_rd;
	logic             store;

	logic             accept;
	logic             out_load;
	logic             pop;
	pend_t            pend_rest;
	rsp_t             rsp_next;
	logic             mem_we;
	logic             mem_re;
	logic [7:0]       mem_rdata;
	logic             mem_busy;

	// Clamp the configured size to 1..MEM_DEPTH
	always_comb begin
		size_raw = CW'(size_q);
		if (size_raw == '0) begin
			size_eff = CW'(1);
		end else if (size_raw > CW'(MEM_DEPTH)) begin
			size_eff = CW'(MEM_DEPTH);
		end else begin
			size_eff = size_raw;
		end
		lim       = PTR_W'(size_eff - CW'(1));
		two_bytes = size_eff > CW'(ONE_BYTE_MAX);
	end

	// Walk stop, start, write and read of one event
	always_comb begin
		sel0 = sel_q;
		idx0 = idx_q;
		ptr0 = ptr_q;
		if (evt.is_stop) begin
			sel0 = '0;
			idx0 = '0;
			ptr0 = '0;
		end
		if (evt.is_start) begin
			sel0 = '0;
			idx0 = '0;
		end
		match     = ((dev_q ^ evt.bus_address) & ~mask_q) == 8'h00;
		ack_start = evt.is_start & match;
		sel1      = ack_start ? evt.bus_address : sel0;
		do_wr     = (sel1 != 8'h00) & evt.is_write;
		do_rd     = (sel1 != 8'h00) & evt.is_read;

		acc0   = (ptr0 > lim) ? lim : ptr0;
		ptr_or = (idx0 == 2'd0) ? (ptr0 | {8'h00, evt.bus_data})
		                        : (ptr0 | {evt.bus_data, 8'h00});
		store  = 1'b0;
		ptr1   = ptr0;
		idx1   = idx0;
		if (do_wr) begin
			if (idx0 == 2'd0 || (idx0 == 2'd1 && two_bytes)) begin
				ptr1 = (ptr_or > lim) ? lim : ptr_or;
			end else begin
				store = 1'b1;
				ptr1  = (acc0 == lim) ? lim : acc0 + PTR_W'(1);
			end
			idx1 = (idx0 == IDX_MAX) ? idx0 : idx0 + 2'd1;
		end

		acc1 = (ptr1 > lim) ? lim : ptr1;
		ptr2 = ptr1;
		idx2 = idx1;
		if (do_rd) begin
			ptr2 = (acc1 == lim) ? lim : acc1 + PTR_W'(1);
			idx2 = (idx1 == IDX_MAX) ? idx1 : idx1 + 2'd1;
		end
	end

	// Drain the reply set one reply per cycle while the receiver does not stall, oldest first
	always_comb begin
		rsp_next               = '0;
		rsp_next.reply_address = addr_s1;
		rsp_next.reply_data    = ACK_DATA;
		pend_rest              = pend_s1;
		priority if (pend_s1.st) begin
			pend_rest.st = 1'b0;
		end else if (pend_s1.wr) begin
			pend_rest.wr = 1'b0;
		end else begin
			rsp_next.reply_is_data = 1'b1;
			rsp_next.reply_data    = fwd_s1 ? fwdd_s1 : mem_rdata;
			pend_rest.rd           = 1'b0;
		end
		rsp_next.last = (pend_rest == '0);
	end

	assign out_load  = !rsp_valid_q || !rsp_stall;
	assign pop       = out_load && (pend_s1 != '0);
	assign evt_stall = mem_busy || !((pend_s1 == '0) || ($onehot(pend_s1) && pop));
	assign accept    = evt_valid && !evt_stall;
	assign mem_we    = accept && store;
	assign mem_re    = accept && do_rd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q  <= DEV_ADDR_RST;
			mask_q <= ADDR_MASK_RST;
			size_q <= MEM_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEV_ADDR:  dev_q  <= cfg_wdata[7:0];
				REG_ADDR_MASK: mask_q <= cfg_wdata[7:0];
				REG_MEM_SIZE:  size_q <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Commit selection, pointer and index; load the reply set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= '0;
			idx_q   <= '0;
			ptr_q   <= '0;
			pend_s1 <= '0;
		end else if (accept) begin
			sel_q   <= sel1;
			idx_q   <= idx2;
			ptr_q   <= ptr2;
			pend_s1 <= '{rd: do_rd, wr: do_wr, st: ack_start};
		end else if (pop) begin
			pend_s1 <= pend_rest;
		end
	end

	// Payload of the reply set; forward a byte stored and read by the same item
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= sel1;
			fwd_s1  <= store && do_rd && (acc0 == acc1);
			fwdd_s1 <= evt.bus_data;
		end
	end

	// Reply register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= (pend_s1 != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	i2cee_store #(
		.DEPTH(MEM_DEPTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (mem_we),
		.wr_addr(acc0[AW-1:0]),
		.wr_data(evt.bus_data),
		.rd_en  (mem_re),
		.rd_addr(acc1[AW-1:0]),
		.rd_data(mem_rdata),
		.busy   (mem_busy)
	);

	// An item only enters while its predecessor hands over its final reply
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pend_s1 != '0) |-> ($onehot(pend_s1) && pop))
		else $error("item accepted over pending replies");

	// A read reply always closes its item
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.reply_is_data) |-> rsp.last)
		else $error("read reply not last");

	// Byte index saturates at two
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3)
		else $error("byte index overflow");

	// No item is taken while the storage sweep runs
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_busy |-> !accept)
		else $error("item accepted during storage sweep");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
	import i2cee_pkg::*;

	localparam int EVT_W        = $bits(evt_t);
	localparam int HOLD_CYCLES  = 300;
	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_GAP   = 8;

	typedef enum logic {ROW_EVT, ROW_CFG} row_kind_t;

	// One line of the directed table: a bus event or a register write
	typedef struct {
		row_kind_t        kind;
		evt_t             ev;
		int               lit_n;   // -1: use predictor, else count of typed-in replies
		rsp_t             lit;
		cfg_reg_t         cfg_sel;
		logic [CFG_W-1:0] cfg_val;
	} dir_row_t;

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             evt_valid = 1'b0;
	logic             evt_stall;
	evt_t             evt       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	logic             cfg_we    = 1'b0;
	logic [1:0]       cfg_index = REG_DEV_ADDR;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// Shadow of the target: registers, bus state and storage
	logic [7:0]        dev_reg  = DEV_ADDR_RST;
	logic [7:0]        mask_reg = ADDR_MASK_RST;
	logic [SIZE_W-1:0] size_reg = MEM_SIZE_RST;
	logic [7:0]        sel_addr = 8'd0;
	logic [1:0]        byte_idx = 2'd0;
	int unsigned       eeprom_ptr = 0;
	logic [7:0]        mem_image [MEM_DEPTH_DEF];

	rsp_t     pending_replies [$];
	dir_row_t dir_tab [$];
	int       bad_count  = 0;
	int       sent_items = 0;
	int       idle_pct   = 0;
	int       stall_pct  = 0;
	logic     hold_go    = 1'b0;

	i2c_eeprom_target u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic evt_t mk_evt(input logic stp, input logic sta, input logic wr,
			input logic rd, input logic [7:0] addr, input logic [7:0] data);
		evt_t e;
		e.is_stop     = stp;
		e.is_start    = sta;
		e.is_write    = wr;
		e.is_read     = rd;
		e.bus_address = addr;
		e.bus_data    = data;
		return e;
	endfunction

	function automatic rsp_t mk_rsp(input logic is_data, input logic [7:0] addr,
			input logic [7:0] data, input logic lst);
		rsp_t r;
		r.reply_is_data = is_data;
		r.reply_address = addr;
		r.reply_data    = data;
		r.last          = lst;
		return r;
	endfunction

	function automatic int unsigned eff_size();
		int unsigned s;
		s = 32'(size_reg);
		if (s < 1) s = 1;
		if (s > MEM_DEPTH_DEF) s = MEM_DEPTH_DEF;
		return s;
	endfunction

	// Advance the shadow by one event and collect the replies it causes
	function automatic void predict_event(input evt_t e, output rsp_t out [3], output int n);
		int unsigned size;
		int unsigned ptr_bytes;
		int unsigned a;
		logic [7:0]  keep;
		size      = eff_size();
		ptr_bytes = (size > ONE_BYTE_MAX) ? 2 : 1;
		keep      = ~mask_reg;
		n         = 0;
		for (int i = 0; i < 3; i++) out[i] = '0;
		if (e.is_stop) begin
			sel_addr   = 8'd0;
			eeprom_ptr = 0;
			byte_idx   = 2'd0;
		end
		if (e.is_start) begin
			sel_addr = 8'd0;
			byte_idx = 2'd0;
			if ((dev_reg & keep) == (e.bus_address & keep)) begin
				sel_addr = e.bus_address;
				out[n]   = mk_rsp(1'b0, sel_addr, ACK_DATA, 1'b0);
				n++;
			end
		end
		if (sel_addr != 8'd0) begin
			if (e.is_write) begin
				out[n] = mk_rsp(1'b0, sel_addr, ACK_DATA, 1'b0);
				n++;
				// pointer bytes first, low byte first; then data bytes
				if (byte_idx < ptr_bytes) begin
					eeprom_ptr = (eeprom_ptr | (32'(e.bus_data) << (8 * byte_idx))) & 32'hFFFF;
				end else begin
					a             = (eeprom_ptr < size) ? eeprom_ptr : size - 1;
					mem_image[a]  = e.bus_data;
					eeprom_ptr    = a + 1;
				end
				if (eeprom_ptr >= size) eeprom_ptr = size - 1;
				if (byte_idx < 2) byte_idx++;
			end
			if (e.is_read) begin
				a      = (eeprom_ptr < size) ? eeprom_ptr : size - 1;
				out[n] = mk_rsp(1'b1, sel_addr, mem_image[a], 1'b0);
				n++;
				eeprom_ptr = a + 1;
				if (eeprom_ptr >= size) eeprom_ptr = size - 1;
				if (byte_idx < 2) byte_idx++;
			end
		end
		if (n > 0) out[n-1].last = 1'b1;
	endfunction

	function automatic void row_evt(input evt_t e, input int lit_n, input rsp_t lit);
		dir_row_t r;
		r.kind    = ROW_EVT;
		r.ev      = e;
		r.lit_n   = lit_n;
		r.lit     = lit;
		r.cfg_sel = REG_DEV_ADDR;
		r.cfg_val = '0;
		dir_tab.push_back(r);
	endfunction

	function automatic void row_cfg(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
		dir_row_t r;
		r.kind    = ROW_CFG;
		r.ev      = '0;
		r.lit_n   = 0;
		r.lit     = '0;
		r.cfg_sel = sel;
		r.cfg_val = val;
		dir_tab.push_back(r);
	endfunction

	// Write one register and mirror it in the shadow
	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		unique case (sel)
			REG_DEV_ADDR:  dev_reg  = val[7:0];
			REG_ADDR_MASK: mask_reg = val[7:0];
			REG_MEM_SIZE:  size_reg = val[SIZE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_regs(input logic [7:0] dev, input logic [7:0] mask,
			input logic [CFG_W-1:0] size);
		write_reg(REG_DEV_ADDR, CFG_W'(dev));
		write_reg(REG_ADDR_MASK, CFG_W'(mask));
		write_reg(REG_MEM_SIZE, size);
	endtask

	// Drop valid, wait out every expected reply, then let the pipe go quiet
	task automatic settle();
		evt_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	// Offer one item, hold it until taken, then queue its replies
	task automatic drive_event(input evt_t e, input int lit_n, input rsp_t lit, output int n);
		rsp_t got [3];
		while ($urandom_range(0, 99) < idle_pct) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt_valid <= 1'b1;
		evt       <= e;
		@(posedge clk);
		while (evt_stall) @(posedge clk);
		predict_event(e, got, n);
		if (lit_n >= 0) begin
			if (lit_n > 0) pending_replies.push_back(lit);
		end else begin
			for (int i = 0; i < n; i++) pending_replies.push_back(got[i]);
		end
		sent_items++;
	endtask

	// Mostly well-formed transfers with random content, some noise
	task automatic run_traffic(input int goal);
		int          stop_at;
		int          n;
		int          ops;
		int unsigned sz;
		int unsigned tgt;
		logic [7:0]  addr;
		evt_t        e;
		stop_at = sent_items + goal;
		while (sent_items < stop_at) begin
			if ($urandom_range(0, 99) < 80) begin
				sz   = eff_size();
				addr = (8'($urandom) & mask_reg) | (dev_reg & ~mask_reg);
				if ($urandom_range(0, 9) == 0) addr = 8'($urandom);
				e = mk_evt($urandom_range(0, 3) == 0, 1'b1, 1'b0, 1'b0, addr, 8'($urandom));
				drive_event(e, -1, '0, n);
				tgt = $urandom_range(0, sz - 1);
				if ($urandom_range(0, 7) == 0) tgt = $urandom_range(0, 65535);
				for (int k = 0; k < ((sz > ONE_BYTE_MAX) ? 2 : 1); k++) begin
					e = mk_evt(1'b0, 1'b0, 1'b1, 1'b0, 8'($urandom), 8'(tgt >> (8 * k)));
					drive_event(e, -1, '0, n);
				end
				ops = $urandom_range(1, 6);
				repeat (ops) begin
					e = mk_evt(1'b0, 1'b0, 1'($urandom), 1'($urandom), 8'($urandom),
						8'($urandom));
					if ($urandom_range(0, 7) == 0) begin
						e.is_start    = 1'b1;
						e.bus_address = addr;
					end
					drive_event(e, -1, '0, n);
				end
				if ($urandom_range(0, 3) != 0) begin
					e = mk_evt(1'b1, 1'($urandom), 1'b0, 1'b0, addr, 8'($urandom));
					drive_event(e, -1, '0, n);
				end
			end else begin
				e = evt_t'(EVT_W'($urandom));
				drive_event(e, -1, '0, n);
			end
		end
	endtask

	// Receiver: random stall, or a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_go) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_go = 1'b0;
			end
			rsp_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Check each reply taken against the oldest expectation
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_replies.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("unexpected reply: is_data=%0b addr=%h data=%h last=%0b",
						rsp.reply_is_data, rsp.reply_address, rsp.reply_data, rsp.last);
			end else begin
				want = pending_replies.pop_front();
				if (rsp.reply_is_data !== want.reply_is_data ||
						rsp.reply_address !== want.reply_address ||
						rsp.reply_data !== want.reply_data || rsp.last !== want.last) begin
					bad_count++;
					if (bad_count <= 10)
						$display("reply mismatch: want %0b/%h/%h/%0b got %0b/%h/%h/%0b",
							want.reply_is_data, want.reply_address, want.reply_data,
							want.last, rsp.reply_is_data, rsp.reply_address,
							rsp.reply_data, rsp.last);
				end
			end
		end
	end

	initial begin
		#(LIMIT_CYCLES * 12);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int n;
		for (int i = 0; i < MEM_DEPTH_DEF; i++) mem_image[i] = ERASED;

		// Directed table: plain transfer, combined flags, repeated start,
		// pointer clamp, no match, address zero, pointer past a lowered size,
		// size out of range at both ends
		row_evt(mk_evt(1'b0, 1'b1, 1'b0, 1'b0, 8'hA0, 8'h00), 1,
			mk_rsp(1'b0, 8'hA0, ACK_DATA, 1'b1));
		row_evt(mk_evt(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h12), 1,
			mk_rsp(1'b0, 8'hA0, ACK_DATA, 1'b1));
		row_evt(mk_evt(1'b0, 1'b0, 1'b1, 1'b0, 8'hFF, 8'h00), 1,
			mk_rsp(1'b0, 8'hA0, ACK_DATA, 1'b1));
		row_evt(mk_evt(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00), 1,
			mk_rsp(1'b1, 8'hA0, ERASED, 1'b1));
		row_evt(mk_evt(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'hAB), 1,
			mk_rsp(1'b0, 8'hA0, ACK_DATA, 1'b1));
		row_evt(mk_evt(1'b1, 1'b1, 1'b1, 1'b1, 8'hA1, 8'h12), -1, '0);
		row_evt(mk_evt(1'b0, 1'b1, 1'b0, 1'b1, 8'hA1, 8'h00), -1, '0);
		row_evt(mk_evt(1'b0, 1'b1, 1'b1, 1'b0, 8'hA0, 8'hFF), -1, '0);
		row_evt(mk_evt(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'hFF), -1, '0);
		row_evt(mk_evt(1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 8'h5A), -1, '0);
		row_evt(mk_evt(1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 8'h00), -1, '0);
		row_evt(mk_evt(1'b0, 1'b1, 1'b0, 1'b0, 8'h50, 8'hFF), 0, '0);
		row_evt(mk_evt(1'b0, 1'b0, 1'b1, 1'b0, 8'h50, 8'h00), 0, '0);
		row_evt(mk_evt(1'b0, 1'b0, 1'b0, 1'b1, 8'h50, 8'h00), 0, '0);
		row_evt(mk_evt(1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF), 0, '0);
		row_cfg(REG_DEV_ADDR, 13'd0);
		row_cfg(REG_ADDR_MASK, 13'd0);
		row_evt(mk_evt(1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00), 1,
			mk_rsp(1'b0, 8'h00, ACK_DATA, 1'b1));
		row_evt(mk_evt(1'b0, 1'b1, 1'b1, 1'b1, 8'h00, 8'hFF), 1,
			mk_rsp(1'b0, 8'h00, ACK_DATA, 1'b1));
		row_evt(mk_evt(1'b0, 1'b1, 1'b0, 1'b0, 8'h01, 8'h00), 0, '0);
		row_cfg(REG_DEV_ADDR, 13'd255);
		row_cfg(REG_ADDR_MASK, 13'd255);
		row_cfg(REG_MEM_SIZE, 13'd16);
		row_evt(mk_evt(1'b0, 1'b1, 1'b0, 1'b1, 8'h37, 8'h00), -1, '0);
		row_evt(mk_evt(1'b0, 1'b0, 1'b1, 1'b0, 8'h37, 8'h3C), -1, '0);
		row_evt(mk_evt(1'b1, 1'b1, 1'b0, 1'b1, 8'h80, 8'h00), -1, '0);
		row_cfg(REG_MEM_SIZE, 13'd0);
		row_evt(mk_evt(1'b0, 1'b1, 1'b1, 1'b1, 8'hFE, 8'h77), -1, '0);
		row_evt(mk_evt(1'b0, 1'b0, 1'b1, 1'b0, 8'hFE, 8'h99), -1, '0);
		row_cfg(REG_MEM_SIZE, 13'd8191);
		row_evt(mk_evt(1'b1, 1'b1, 1'b0, 1'b1, 8'h42, 8'h00), -1, '0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				settle();
				write_reg(dir_tab[i].cfg_sel, dir_tab[i].cfg_val);
			end else begin
				drive_event(dir_tab[i].ev, dir_tab[i].lit_n, dir_tab[i].lit, n);
			end
		end

		// Random phases: idling mode and register setting change together
		settle();
		set_regs(DEV_ADDR_RST, ADDR_MASK_RST, MEM_SIZE_RST);
		idle_pct  = 0;
		stall_pct = 0;
		run_traffic(55);

		settle();
		set_regs(8'($urandom), 8'h00, 13'd256);
		idle_pct  = 81;
		stall_pct = 0;
		run_traffic(55);

		settle();
		set_regs(8'($urandom), 8'hFF, 13'd255);
		idle_pct  = 0;
		stall_pct = 81;
		run_traffic(55);

		settle();
		set_regs(8'($urandom), 8'($urandom), 13'd1);
		idle_pct  = 31;
		stall_pct = 31;
		run_traffic(55);

		// Long receiver hold-off while items keep coming, then a full pause
		settle();
		set_regs(8'($urandom), 8'h0F, CFG_W'($urandom_range(2, 300)));
		idle_pct  = 0;
		stall_pct = 0;
		hold_go   = 1'b1;
		run_traffic(25);
		settle();
		run_traffic(25);

		evt_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (bad_count == 0 && pending_replies.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
rtl/i2cee_pkg.sv
rtl/i2cee_store.sv
rtl/i2c_eeprom_target.sv
tb/testbench.sv
